[hdl/pf_pkg.sv]
// Shared types, constants and grid arithmetic for the Playfair encryption engine.
package pf_pkg;

    localparam int GRID_SIZE   = 5;
    localparam int CELLS       = GRID_SIZE * GRID_SIZE;
    localparam int NUM_LETTERS = 26;

    localparam logic [4:0] LETTER_I    = 5'd8;
    localparam logic [4:0] LETTER_J    = 5'd9;
    localparam logic [4:0] LETTER_X    = 5'd23;
    localparam logic [4:0] LETTER_LAST = 5'd25;

    localparam logic [1:0] KIND_KEY = 2'd0;
    localparam logic [1:0] KIND_END = 2'd1;
    localparam logic [1:0] KIND_MSG = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [4:0] letter;
        logic       last_letter;
    } in_word_t;

    typedef struct packed {
        logic [4:0] cipher_letter;
        logic       last_of_run;
    } out_word_t;

    // write request into the grid and position tables
    typedef struct packed {
        logic       en;
        logic [4:0] slot;
        logic [4:0] letter;
    } grid_wr_t;

    function automatic logic [2:0] grid_row(input logic [4:0] p);
        logic [2:0] r;
        begin
            if (p >= 5'(4 * GRID_SIZE))
                r = 3'd4;
            else if (p >= 5'(3 * GRID_SIZE))
                r = 3'd3;
            else if (p >= 5'(2 * GRID_SIZE))
                r = 3'd2;
            else if (p >= 5'(GRID_SIZE))
                r = 3'd1;
            else
                r = 3'd0;
            return r;
        end
    endfunction

    function automatic logic [4:0] row_base(input logic [2:0] r);
        begin
            return {r, 2'b00} + {2'b00, r};
        end
    endfunction

    function automatic logic [2:0] grid_col(input logic [4:0] p);
        logic [4:0] t;
        begin
            t = p - row_base(grid_row(p));
            return t[2:0];
        end
    endfunction

    function automatic logic [2:0] wrap_next(input logic [2:0] v);
        begin
            return (v == 3'(GRID_SIZE - 1)) ? 3'd0 : v + 3'd1;
        end
    endfunction

    function automatic logic [4:0] cell_index(input logic [2:0] r, input logic [2:0] c);
        begin
            return row_base(r) + {2'b00, c};
        end
    endfunction

endpackage

[hdl/playfair_cipher_encrypt.sv]
// Playfair encryption engine: key entry, grid fill, pairing and result output.
//
// Input words arrive on item (valid/stall); results leave on result (valid/stall).
// A key letter is placed as it is accepted. A key-end word sweeps all 26 letters,
// one a cycle, so the block stalls its input while the grid fills.
// A message word that completes a pair starts the pair unit: the letter
// position memory is read, then the grid memory; both cipher letters are
// registered there and leave one a cycle through the output register while
// the receiver does not stall. The word that ends a doubled letter at the end
// of the text makes two pairs. The input stays stalled until the last cipher
// letter of the word is loaded into the output register; a word that only
// holds a letter does not stall the input.
// The output register lets a new word in while the last result waits.
// A stalled receiver holds the result and, once the FSM needs the register,
// holds the input too. Reset empties the grid state, the held letter and the
// output register; memory contents are not cleared.
module playfair_cipher_encrypt (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  pf_pkg::in_word_t  item,
    output logic              result_valid,
    input  logic              result_stall,
    output pf_pkg::out_word_t result
);
    import pf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_WAIT,
        ST_EMIT_X,
        ST_EMIT_Y
    } state_t;

    state_t                   state_reg;
    logic [NUM_LETTERS-1:0]   used_reg;
    logic [4:0]               fill_reg;
    logic                     complete_reg;
    logic [4:0]               pend_letter_reg;
    logic                     pend_valid_reg;
    logic [4:0]               sweep_reg;
    logic                     second_reg;
    logic [4:0]               second_letter_reg;
    logic                     result_valid_reg;
    out_word_t                result_reg;

    logic                     accept;
    logic [4:0]               letter_f;
    logic                     letter_ok;
    logic [NUM_LETTERS-1:0]   used_eff;
    logic [4:0]               fill_eff;
    logic                     do_key;
    logic                     key_place;
    logic                     fill_place;
    logic                     do_msg;
    logic                     match;
    logic                     msg_start;
    logic                     out_load;
    logic                     emit_load;
    logic                     second_start;
    logic                     pair_start;
    logic [4:0]               pair_a;
    logic [4:0]               pair_b;
    grid_wr_t                 grid_wr;
    logic                     pair_done;
    logic [4:0]               pair_x;
    logic [4:0]               pair_y;

    always_comb
    begin
        item_stall = (state_reg != ST_IDLE);
        accept     = item_valid && !item_stall;
        letter_f   = (item.letter == LETTER_J) ? LETTER_I : item.letter;
        letter_ok  = (letter_f <= LETTER_LAST);
        // a key letter after a finished grid starts a fresh key
        used_eff   = complete_reg ? '0 : used_reg;
        fill_eff   = complete_reg ? 5'd0 : fill_reg;

        do_key     = accept && (item.kind == KIND_KEY) && letter_ok;
        key_place  = do_key && !used_eff[letter_f] && (fill_eff < 5'(CELLS));
        fill_place = (state_reg == ST_FILL) && (sweep_reg != LETTER_J)
                     && !used_reg[sweep_reg] && (fill_reg < 5'(CELLS));

        grid_wr.en     = key_place || fill_place;
        grid_wr.slot   = key_place ? fill_eff : fill_reg;
        grid_wr.letter = key_place ? letter_f : sweep_reg;

        do_msg    = accept && (item.kind == KIND_MSG) && complete_reg && letter_ok;
        match     = pend_valid_reg && (letter_f == pend_letter_reg);
        msg_start = do_msg && (pend_valid_reg || item.last_letter);

        out_load     = !result_valid_reg || !result_stall;
        emit_load    = out_load && ((state_reg == ST_EMIT_X) || (state_reg == ST_EMIT_Y));
        second_start = (state_reg == ST_EMIT_Y) && out_load && second_reg;
        pair_start   = msg_start || second_start;

        if (state_reg == ST_EMIT_Y)
        begin
            pair_a = second_letter_reg;
            pair_b = LETTER_X;
        end
        else
        begin
            pair_a = pend_valid_reg ? pend_letter_reg : letter_f;
            pair_b = (pend_valid_reg && !match) ? letter_f : LETTER_X;
        end
    end

    pf_pair_unit u_pair (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (grid_wr),
        .start (pair_start),
        .a     (pair_a),
        .b     (pair_b),
        .done  (pair_done),
        .x     (pair_x),
        .y     (pair_y)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            used_reg          <= '0;
            fill_reg          <= 5'd0;
            complete_reg      <= 1'b0;
            pend_letter_reg   <= 5'd0;
            pend_valid_reg    <= 1'b0;
            sweep_reg         <= 5'd0;
            second_reg        <= 1'b0;
            second_letter_reg <= 5'd0;
            result_valid_reg  <= 1'b0;
            result_reg        <= '0;
        end
        else
        begin
            result_valid_reg <= emit_load || (result_valid_reg && result_stall);

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (do_key)
                    begin
                        used_reg <= key_place
                                    ? (used_eff | (NUM_LETTERS'(1) << letter_f))
                                    : used_eff;
                        fill_reg <= key_place ? fill_eff + 5'd1 : fill_eff;
                        if (complete_reg)
                        begin
                            complete_reg    <= 1'b0;
                            pend_valid_reg  <= 1'b0;
                            pend_letter_reg <= 5'd0;
                        end
                    end
                    else if (accept && (item.kind == KIND_END) && !complete_reg)
                    begin
                        sweep_reg <= 5'd0;
                        state_reg <= ST_FILL;
                    end
                    else if (do_msg)
                    begin
                        second_letter_reg <= letter_f;
                        if (pend_valid_reg && match)
                        begin
                            // doubled letter: pair with X, keep this letter
                            second_reg      <= item.last_letter;
                            pend_valid_reg  <= !item.last_letter;
                            pend_letter_reg <= item.last_letter ? 5'd0 : letter_f;
                        end
                        else if (pend_valid_reg || item.last_letter)
                        begin
                            second_reg      <= 1'b0;
                            pend_valid_reg  <= 1'b0;
                            pend_letter_reg <= 5'd0;
                        end
                        else
                        begin
                            pend_valid_reg  <= 1'b1;
                            pend_letter_reg <= letter_f;
                        end
                        if (msg_start)
                            state_reg <= ST_WAIT;
                    end
                end

                ST_FILL:
                begin
                    if (fill_place)
                    begin
                        used_reg <= used_reg | (NUM_LETTERS'(1) << sweep_reg);
                        fill_reg <= fill_reg + 5'd1;
                    end
                    if (sweep_reg == LETTER_LAST)
                    begin
                        complete_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                    else
                        sweep_reg <= sweep_reg + 5'd1;
                end

                ST_WAIT:
                begin
                    if (pair_done)
                        state_reg <= ST_EMIT_X;
                end

                ST_EMIT_X:
                begin
                    if (out_load)
                    begin
                        result_reg.cipher_letter <= pair_x;
                        result_reg.last_of_run   <= 1'b0;
                        state_reg                <= ST_EMIT_Y;
                    end
                end

                ST_EMIT_Y:
                begin
                    if (out_load)
                    begin
                        result_reg.cipher_letter <= pair_y;
                        result_reg.last_of_run   <= !second_reg;
                        if (second_reg)
                        begin
                            second_reg <= 1'b0;
                            state_reg  <= ST_WAIT;
                        end
                        else
                            state_reg <= ST_IDLE;
                    end
                end

                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

[hdl/pf_pair_unit.sv]
// Key grid and letter position memories, and the two-stage pair encipher path.
module pf_pair_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  pf_pkg::grid_wr_t wr,
    input  logic             start,
    input  logic [4:0]       a,
    input  logic [4:0]       b,
    output logic             done,
    output logic [4:0]       x,
    output logic [4:0]       y
);
    import pf_pkg::*;

    logic [4:0] grid_mem [CELLS];
    logic [4:0] pos_mem  [NUM_LETTERS];

    logic [4:0] pos_a_reg;
    logic [4:0] pos_b_reg;
    logic [4:0] x_reg;
    logic [4:0] y_reg;
    logic       s1_reg;
    logic       done_reg;

    logic [2:0] r1, c1, r2, c2;
    logic [4:0] cell_a, cell_b;

    // one write port shared by both tables: letter at cell, cell of letter
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            grid_mem[wr.slot] <= wr.letter;
            pos_mem[wr.letter] <= wr.slot;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_a_reg <= pos_mem[a];
        pos_b_reg <= pos_mem[b];
    end

    always_comb
    begin
        r1 = grid_row(pos_a_reg);
        c1 = grid_col(pos_a_reg);
        r2 = grid_row(pos_b_reg);
        c2 = grid_col(pos_b_reg);
        if (r1 == r2)
        begin
            cell_a = cell_index(r1, wrap_next(c1));
            cell_b = cell_index(r2, wrap_next(c2));
        end
        else if (c1 == c2)
        begin
            cell_a = cell_index(wrap_next(r1), c1);
            cell_b = cell_index(wrap_next(r2), c2);
        end
        else
        begin
            cell_a = cell_index(r1, c2);
            cell_b = cell_index(r2, c1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_reg)
        begin
            x_reg <= grid_mem[cell_a];
            y_reg <= grid_mem[cell_b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            s1_reg   <= start;
            done_reg <= s1_reg;
        end
    end

    assign done = done_reg;
    assign x    = x_reg;
    assign y    = y_reg;

endmodule

[tb/sv/tb_top.sv]
// Testbench for the Playfair encryption engine: directed and random words, checked by a predictor.
`timescale 1ns / 1ps

module tb_top;
    import pf_pkg::*;

    localparam logic [1:0] KIND_NONE = 2'd3;

    logic      clk;
    logic      rst_n        = 1'b0;
    logic      item_valid   = 1'b0;
    logic      item_stall;
    in_word_t  item         = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    out_word_t result;

    playfair_cipher_encrypt u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // predictor state
    logic [4:0]  grid_cells [CELLS];
    logic [4:0]  cell_of [NUM_LETTERS];
    logic [25:0] placed;
    int          filled;
    bit          grid_done;
    logic [4:0]  held_letter;
    bit          held_valid;
    out_word_t   run_buf [4];
    int          run_n;

    in_word_t    word_q [$];
    out_word_t   cipher_due_q [$];
    out_word_t   due_word;

    int words_offered = 0;
    int words_in      = 0;
    int words_total   = 0;
    int quiet_from    = 0;
    int results_seen  = 0;
    int grids_built   = 0;
    int errors        = 0;
    int send_gap      = 0;
    int stall_left    = 0;
    int hold_left     = 0;
    bit held_off      = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400_000;
        $display("tb: failure");
        $finish;
    end

    task automatic flag_mismatch(input string what, input int got, input int want);
        begin
            $display("tb: mismatch at %0t: %s, got %0d, want %0d",
                     $realtime, what, got, want);
            errors++;
        end
    endtask

    function automatic void place_letter(input logic [4:0] l);
        begin
            if (l > LETTER_LAST || l == LETTER_J || placed[l] || filled >= CELLS)
                return;
            grid_cells[filled] = l;
            cell_of[l] = 5'(filled);
            placed[l] = 1'b1;
            filled++;
        end
    endfunction

    // appends the two cipher letters of pair (a, b) to run_buf
    function automatic void pair_cipher(input logic [4:0] a, input logic [4:0] b);
        int r1, c1, r2, c2;
        begin
            r1 = cell_of[a] / GRID_SIZE;
            c1 = cell_of[a] % GRID_SIZE;
            r2 = cell_of[b] / GRID_SIZE;
            c2 = cell_of[b] % GRID_SIZE;
            run_buf[run_n].last_of_run = 1'b0;
            run_buf[run_n + 1].last_of_run = 1'b0;
            if (r1 == r2)
            begin
                run_buf[run_n].cipher_letter = grid_cells[r1 * GRID_SIZE + (c1 + 1) % GRID_SIZE];
                run_buf[run_n + 1].cipher_letter = grid_cells[r2 * GRID_SIZE + (c2 + 1) % GRID_SIZE];
            end
            else if (c1 == c2)
            begin
                run_buf[run_n].cipher_letter = grid_cells[((r1 + 1) % GRID_SIZE) * GRID_SIZE + c1];
                run_buf[run_n + 1].cipher_letter = grid_cells[((r2 + 1) % GRID_SIZE) * GRID_SIZE + c2];
            end
            else
            begin
                run_buf[run_n].cipher_letter = grid_cells[r1 * GRID_SIZE + c2];
                run_buf[run_n + 1].cipher_letter = grid_cells[r2 * GRID_SIZE + c1];
            end
            run_n += 2;
        end
    endfunction

    function automatic void playfair_predict(input in_word_t w);
        logic [4:0] l;
        begin
            l = (w.letter == LETTER_J) ? LETTER_I : w.letter;
            run_n = 0;
            if (w.kind == KIND_KEY && l <= LETTER_LAST)
            begin
                // fresh key wipes the old grid and any held letter
                if (grid_done)
                begin
                    placed = '0;
                    filled = 0;
                    grid_done = 1'b0;
                    held_valid = 1'b0;
                    held_letter = '0;
                end
                place_letter(l);
            end
            else if (w.kind == KIND_END && !grid_done)
            begin
                for (int i = 0; i < NUM_LETTERS; i++)
                    place_letter(5'(i));
                grid_done = 1'b1;
                grids_built++;
            end
            else if (w.kind == KIND_MSG && grid_done && l <= LETTER_LAST)
            begin
                if (!held_valid)
                begin
                    held_letter = l;
                    held_valid = 1'b1;
                end
                else if (l == held_letter)
                    pair_cipher(held_letter, LETTER_X);
                else
                begin
                    pair_cipher(held_letter, l);
                    held_valid = 1'b0;
                    held_letter = '0;
                end
                if (w.last_letter && held_valid)
                begin
                    pair_cipher(held_letter, LETTER_X);
                    held_valid = 1'b0;
                    held_letter = '0;
                end
            end
            for (int i = 0; i < run_n; i++)
            begin
                if (i == run_n - 1)
                    run_buf[i].last_of_run = 1'b1;
                cipher_due_q.push_back(run_buf[i]);
            end
        end
    endfunction

    function automatic bit calm_phase();
        begin
            return (words_in >= quiet_from) || (words_in % 50 < 12) || (hold_left > 0);
        end
    endfunction

    task automatic push_word(input logic [1:0] k, input logic [4:0] l, input logic last);
        in_word_t w;
        begin
            w.kind = k;
            w.letter = l;
            w.last_letter = last;
            word_q.push_back(w);
        end
    endtask

    function automatic logic [4:0] ltr(input byte c);
        begin
            return 5'(c - 8'd65);
        end
    endfunction

    // sender
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!item_valid || words_in == words_offered)
            begin
                if (send_gap > 0)
                begin
                    item_valid <= 1'b0;
                    send_gap--;
                end
                else if (!calm_phase() && $urandom_range(0, 4) == 0)
                begin
                    item_valid <= 1'b0;
                    send_gap = $urandom_range(0, 2);
                end
                else if (word_q.size() > 0)
                begin
                    item <= word_q.pop_front();
                    item_valid <= 1'b1;
                    words_offered++;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            // one long hold-off mid-text so the block backs up into its input
            if (!held_off && words_in >= 60 && item_valid && item.kind == KIND_MSG)
            begin
                hold_left = 80;
                held_off = 1'b1;
            end
            if (hold_left > 0)
            begin
                result_stall <= 1'b1;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                result_stall <= 1'b1;
                stall_left--;
            end
            else if (!calm_phase() && $urandom_range(0, 4) == 0)
            begin
                result_stall <= 1'b1;
                stall_left = $urandom_range(0, 2);
            end
            else
                result_stall <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (cipher_due_q.size() == 0)
                    flag_mismatch("unexpected result word", int'(result.cipher_letter), 0);
                else
                begin
                    due_word = cipher_due_q.pop_front();
                    if (result.cipher_letter !== due_word.cipher_letter)
                        flag_mismatch("cipher_letter", int'(result.cipher_letter),
                                      int'(due_word.cipher_letter));
                    if (result.last_of_run !== due_word.last_of_run)
                        flag_mismatch("last_of_run", int'(result.last_of_run),
                                      int'(due_word.last_of_run));
                    results_seen++;
                end
            end
            if (item_valid && !item_stall)
            begin
                playfair_predict(item);
                words_in++;
            end
        end
    end

    initial
    begin
        int         run_len;
        int         pick;
        logic [4:0] l;
        logic [4:0] prev;
        logic       last;

        placed = '0;
        filled = 0;
        grid_done = 1'b0;
        held_letter = '0;
        held_valid = 1'b0;

        // directed: text before any grid, bad letters, J folding, repeated key end
        push_word(KIND_MSG, ltr("H"), 1'b0);
        push_word(KIND_KEY, 5'd31, 1'b1);
        push_word(KIND_KEY, LETTER_LAST, 1'b1);
        push_word(KIND_KEY, LETTER_J, 1'b0);
        push_word(KIND_KEY, LETTER_I, 1'b0);
        push_word(KIND_KEY, 5'd0, 1'b0);
        push_word(KIND_KEY, LETTER_X, 1'b0);
        push_word(KIND_END, 5'd31, 1'b1);
        push_word(KIND_END, 5'd0, 1'b0);
        push_word(KIND_NONE, 5'd31, 1'b1);
        // doubled letter, J in text, X X pair, lone last, doubled at the end
        push_word(KIND_MSG, ltr("A"), 1'b0);
        push_word(KIND_MSG, ltr("A"), 1'b0);
        push_word(KIND_MSG, LETTER_J, 1'b0);
        push_word(KIND_MSG, LETTER_X, 1'b0);
        push_word(KIND_MSG, LETTER_X, 1'b0);
        push_word(KIND_MSG, 5'd27, 1'b0);
        push_word(KIND_MSG, LETTER_LAST, 1'b1);
        push_word(KIND_MSG, ltr("F"), 1'b1);
        push_word(KIND_MSG, ltr("H"), 1'b0);
        push_word(KIND_MSG, ltr("H"), 1'b1);
        // held letter dropped by a fresh key; text ignored until the key ends
        push_word(KIND_MSG, ltr("E"), 1'b0);
        push_word(KIND_KEY, ltr("D"), 1'b0);
        push_word(KIND_MSG, ltr("C"), 1'b0);
        push_word(KIND_END, 5'd0, 1'b0);
        push_word(KIND_MSG, 5'd31, 1'b1);

        while (word_q.size() < 130)
        begin
            run_len = $urandom_range(0, 10);
            for (int i = 0; i < run_len; i++)
            begin
                l = ($urandom_range(0, 11) == 0) ? 5'($urandom_range(26, 31))
                                                 : 5'($urandom_range(0, 25));
                push_word(KIND_KEY, l, 1'($urandom_range(0, 1)));
            end
            // broken sequence: text before the key is closed
            if ($urandom_range(0, 9) == 0)
            begin
                run_len = $urandom_range(1, 4);
                for (int i = 0; i < run_len; i++)
                    push_word(KIND_MSG, 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
            end
            push_word(KIND_END, 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 3) == 0)
                push_word(KIND_END, 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
            run_len = $urandom_range(8, 40);
            prev = ltr("A");
            for (int i = 0; i < run_len; i++)
            begin
                if ($urandom_range(0, 24) == 0)
                    push_word(KIND_NONE, 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
                pick = $urandom_range(0, 19);
                if (pick < 3)
                    l = prev;
                else if (pick < 5)
                    l = LETTER_X;
                else if (pick == 5)
                    l = 5'($urandom_range(26, 31));
                else
                    l = 5'($urandom_range(0, 25));
                last = (i == run_len - 1) ? 1'($urandom_range(0, 1))
                                          : ($urandom_range(0, 9) == 0);
                push_word(KIND_MSG, l, last);
                if (l <= LETTER_LAST)
                    prev = l;
            end
        end

        words_total = word_q.size();
        quiet_from = words_total - 30;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (words_in < words_total || cipher_due_q.size() > 0)
            @(negedge clk);
        repeat (30) @(negedge clk);

        $display("tb: %0d input words accepted, %0d cipher letters checked", words_in,
                 results_seen);
        $display("tb: %0d key grids built, %0d mismatches", grids_built, errors);
        if (errors == 0 && cipher_due_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
